// ===== rtl/qks_pkg.sv =====
`default_nettype none
package qks_pkg;
  localparam int MaxKeysDef = 64;
  localparam int KeyWidthDef = 32;
  localparam int CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegDescending = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_RD_J,
    ST_CMP,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT
  } qks_state_t;
endpackage
`default_nettype wire

// ===== rtl/qks_in_if.sv =====
`default_nettype none
interface qks_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key;
  logic        final_key;
  modport source (output valid, key, final_key, input ready);
  modport sink (input valid, key, final_key, output ready);
endinterface
`default_nettype wire

// ===== rtl/qks_out_if.sv =====
`default_nettype none
interface qks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_key;
  logic        end_of_run;
  logic        overflowed;
  modport source (output valid, sorted_key, end_of_run, overflowed, input ready);
  modport sink (input valid, sorted_key, end_of_run, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/qks_cmp.sv =====
`default_nettype none
module qks_cmp
  import qks_pkg::*;
#(
  parameter int KEY_WIDTH = KeyWidthDef
) (
  input  wire logic [KEY_WIDTH-1:0] a,
  input  wire logic [KEY_WIDTH-1:0] b,
  input  wire logic                 descending,
  output logic                      a_before_b
);
  always_comb begin
    a_before_b = descending ? (b < a) : (a < b);
  end
endmodule
`default_nettype wire

// ===== rtl/quicksort_key_sorter.sv =====
// Key sorter with one shared comparator.
// in: one key per transaction (valid/ready); final_key closes the set.
// Keys are stored one per cycle while loading; up to MAX_KEYS are kept,
// further keys are dropped and the whole set is flagged overflowed.
// After the final key the set is sorted in place by an insertion pass over
// the key memory, which has one write and one read port: each compare step
// reads one entry, compares it against the held key and, on a move, writes
// one entry. Then the keys leave on out, one transaction each: each key is
// read from memory, then loaded on out; end_of_run marks the last.
// in.ready is low from the final key until the last key is loaded on out.
// A stalled receiver holds out valid and payload unchanged.
// cfg: APB write of register 0 bit 0 selects descending order; the user
// must write it only while idle (not enforced). pready is always high.
// Reset (synchronous, rst_n low) empties the set, clears the overflow flag
// and the order register; the key memory needs no clearing.
`default_nettype none
module quicksort_key_sorter
  import qks_pkg::*;
#(
  parameter int MAX_KEYS  = MaxKeysDef,
  parameter int KEY_WIDTH = KeyWidthDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  qks_in_if.sink                   in_ch,
  qks_out_if.source                out_ch,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  qks_state_t state_r, state_nxt;
  logic [KEY_WIDTH-1:0] mem [MAX_KEYS];
  logic [KEY_WIDTH-1:0] rd_r, v_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic ovf_r, ovf_nxt, desc_r;
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic v_first;
  logic in_acc, room, out_ld, out_valid_r, out_last_r;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic out_ovf_r;
  logic last_emit;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegDescending) ? {31'd0, desc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegDescending) begin
      desc_r <= cfg_pwdata[0];
    end
  end

  qks_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .a(v_r), .b(rd_r), .descending(desc_r), .a_before_b(v_first)
  );

  // emit: i counts keys; count cleared on last, so compare before clear
  assign last_emit = (i_r + 1'b1 == count_r);

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign room = (count_r < CW'(MAX_KEYS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && in_ch.final_key) begin
        state_nxt = ST_RD_I;
      end
      ST_RD_I: state_nxt = (i_r >= count_r) ? ST_EMIT_RD : ST_RD_J;
      ST_RD_J: state_nxt = (j_r == '0) ? ST_WR : ST_CMP;
      ST_CMP: state_nxt = v_first ? ST_RD_J : ST_WR;
      ST_WR: state_nxt = ST_RD_I;
      ST_EMIT_RD: state_nxt = (!out_valid_r || out_ch.ready) ? ST_EMIT : ST_EMIT_RD;
      ST_EMIT: state_nxt = last_emit ? ST_LOAD : ST_EMIT_RD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    i_nxt = i_r;
    j_nxt = j_r;
    we = 1'b0;
    waddr = count_r[IW-1:0];
    wdata = KEY_WIDTH'(in_ch.key);
    raddr = i_r[IW-1:0];
    out_ld = 1'b0;
    case (state_r)
      ST_LOAD: if (in_acc) begin
        if (room) begin
          we = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        i_nxt = CW'(1);
      end
      ST_RD_I: begin
        raddr = i_r[IW-1:0];
        j_nxt = i_r;
        if (i_r >= count_r) begin
          i_nxt = '0;
        end
      end
      ST_RD_J: begin
        raddr = IW'(j_r - 1'b1);
      end
      ST_CMP: if (v_first) begin
        we = 1'b1;
        waddr = j_r[IW-1:0];
        wdata = rd_r;
        j_nxt = j_r - 1'b1;
      end
      ST_WR: begin
        we = 1'b1;
        waddr = j_r[IW-1:0];
        wdata = v_r;
        i_nxt = i_r + 1'b1;
      end
      ST_EMIT_RD: begin
        raddr = i_r[IW-1:0];
      end
      ST_EMIT: begin
        out_ld = 1'b1;
        i_nxt = i_r + 1'b1;
        if (last_emit) begin
          count_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
    if (state_r == ST_RD_I) begin
      v_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
        out_last_r <= last_emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_key_r <= rd_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sorted_key = 32'(out_key_r);
  assign out_ch.end_of_run = out_last_r;
  assign out_ch.overflowed = out_ovf_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEYS)) else $error("key count beyond capacity");
  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_LOAD)
    else $error("ready outside load");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_key_r))
    else $error("stalled result changed");
  a_sort_j: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> j_r <= i_r) else $error("insert index ahead");
`endif
endmodule
`default_nettype wire
